// File: rtl/assert_macros.svh
// Assertion macros shared by the relocation patcher RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: rtl/rrp_pkg.sv
// Package for the relocation patcher: constants, types, field encoders.
// Depends on nothing.
package rrp_pkg;
   localparam int HiTableDepth = 64;
   localparam int QueueDepth = 2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_UNSUP = 2'd2;
   localparam logic [1:0] ST_NOHI = 2'd3;

   // classified transaction handed from front to back
   typedef struct packed {
      logic [7:0]  rel_type;
      logic [63:0] sym_value;
      logic [63:0] val;        // S + A, or S + A - P for pc-relative types
      logic [63:0] key;        // S - base, lookup key for LO12
      logic [31:0] place_offset;
      logic [63:0] old_bytes;
      logic        section_start;
      logic        is_hi;
      logic        is_lo;
   } item_type;

   typedef struct packed {
      logic [63:0] new_bytes;
      logic [3:0]  write_bytes;
      logic [1:0]  status;
   } result_type;

   function automatic logic is_pcrel(input logic [7:0] t);
      case (t)
         8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
         8'd44, 8'd45, 8'd57, 8'd59: is_pcrel = 1'b1;
         default: is_pcrel = 1'b0;
      endcase
   endfunction

   function automatic logic fits_i32(input logic [63:0] v);
      fits_i32 = (v[63:31] == {33{v[31]}});
   endfunction

   // low 32 bits as signed, compared against [-lim, lim)
   function automatic logic in_range(input logic [63:0] v, input logic signed [31:0] lim);
      logic signed [31:0] s;
      s = v[31:0];
      in_range = (s < lim) && (s >= -lim);
   endfunction

   function automatic logic [31:0] enc_b(input logic [31:0] w, input logic [63:0] v);
      enc_b = (w & 32'h01fff07f) | {v[12], v[10:5], 13'd0, v[4:1], v[11], 7'd0};
   endfunction

   function automatic logic [31:0] enc_j(input logic [31:0] w, input logic [63:0] v);
      enc_j = (w & 32'h00000fff) | {v[20], v[10:1], v[11], v[19:12], 12'd0};
   endfunction

   function automatic logic [31:0] enc_u(input logic [31:0] w, input logic [63:0] v);
      logic [31:0] t;
      t = v[31:0] + 32'h800;
      enc_u = (w & 32'hfff) | (t & 32'hfffff000);
   endfunction

   function automatic logic [31:0] enc_i(input logic [31:0] w, input logic [63:0] v);
      enc_i = (w & 32'h000fffff) | {v[11:0], 20'd0};
   endfunction

   function automatic logic [31:0] enc_s(input logic [31:0] w, input logic [63:0] v);
      enc_s = (w & 32'h01fff07f) | {v[11:5], 13'd0, v[4:0], 7'd0};
   endfunction

   function automatic logic [15:0] enc_cb(input logic [15:0] h, input logic [63:0] v);
      enc_cb = (h & 16'he383) | {3'd0, v[8], v[4:3], 3'd0, v[7:6], v[2:1], v[5], 2'd0};
   endfunction

   function automatic logic [15:0] enc_cj(input logic [15:0] h, input logic [63:0] v);
      enc_cj = (h & 16'he003) |
         {3'd0, v[11], v[4], v[9:8], v[10], v[6], v[7], v[3:1], v[5], 2'd0};
   endfunction

   function automatic logic [15:0] enc_ci(input logic [15:0] h, input logic [63:0] v);
      enc_ci = (h & 16'hef83) | {3'd0, v[17], 5'd0, v[16:12], 2'd0};
   endfunction

   function automatic logic [63:0] merge(input logic [63:0] old, input logic [63:0] val,
                                         input logic [3:0] n);
      logic [63:0] m;
      case (n)
         4'd1: m = 64'hff;
         4'd2: m = 64'hffff;
         4'd4: m = 64'hffff_ffff;
         4'd8: m = '1;
         default: m = '0;
      endcase
      merge = (old & ~m) | (val & m);
   endfunction

   // everything except the table lookup
   function automatic result_type patch(input item_type it, input logic [63:0] found);
      result_type r;
      logic [63:0] res;
      logic [63:0] v;
      logic [31:0] w;
      logic [15:0] h;
      logic [7:0]  b;
      logic [3:0]  n;
      logic [1:0]  st;
      v = it.val;
      w = it.old_bytes[31:0];
      h = it.old_bytes[15:0];
      b = it.old_bytes[7:0];
      res = '0;
      n = 4'd0;
      st = ST_OK;
      case (it.rel_type)
         8'd0, 8'd32: ;
         8'd2: begin res = v; n = 4'd8; end
         8'd16: if (!in_range(v, 32'sd4096)) st = ST_OVF;
            else begin res = {32'd0, enc_b(w, v)}; n = 4'd4; end
         8'd17: if (!in_range(v, 32'sd1048576)) st = ST_OVF;
            else begin res = {32'd0, enc_j(w, v)}; n = 4'd4; end
         8'd18, 8'd19: begin
            res = {enc_i(it.old_bytes[63:32], v), enc_u(w, v)};
            n = 4'd8;
         end
         8'd20, 8'd21, 8'd22, 8'd23, 8'd26, 8'd29:
            if (!fits_i32(v)) st = ST_OVF;
            else begin res = {32'd0, enc_u(w, v)}; n = 4'd4; end
         8'd24, 8'd25, 8'd27, 8'd28, 8'd30, 8'd31: begin
            if (it.is_lo) begin
               v = found - it.sym_value;
               if (found == 64'd0) st = ST_NOHI;
            end
            if (it.rel_type == 8'd24 || it.rel_type == 8'd27 || it.rel_type == 8'd30)
               res = {32'd0, enc_i(w, v)};
            else
               res = {32'd0, enc_s(w, v)};
            n = 4'd4;
         end
         8'd33: begin res = it.old_bytes + v; n = 4'd1; end
         8'd34: begin res = it.old_bytes + v; n = 4'd2; end
         8'd35: begin res = it.old_bytes + v; n = 4'd4; end
         8'd36: begin res = it.old_bytes + v; n = 4'd8; end
         8'd37: begin res = it.old_bytes - v; n = 4'd1; end
         8'd38: begin res = it.old_bytes - v; n = 4'd2; end
         8'd39: begin res = it.old_bytes - v; n = 4'd4; end
         8'd40: begin res = it.old_bytes - v; n = 4'd8; end
         8'd44: if (!in_range(v, 32'sd256)) st = ST_OVF;
            else begin res = {48'd0, enc_cb(h, v)}; n = 4'd2; end
         8'd45: if (!in_range(v, 32'sd2048)) st = ST_OVF;
            else begin res = {48'd0, enc_cj(h, v)}; n = 4'd2; end
         8'd46: if (!in_range(v, 32'sd131072) || ((v & 64'h3f000) == 64'd0)) st = ST_OVF;
            else begin res = {48'd0, enc_ci(h, v)}; n = 4'd2; end
         8'd52: begin
            res = {56'd0, (b & 8'hc0) | ((b - v[7:0]) & 8'h3f)};
            n = 4'd1;
         end
         8'd53: begin res = {56'd0, (b & 8'hc0) | {2'd0, v[5:0]}}; n = 4'd1; end
         8'd54: begin res = v; n = 4'd1; end
         8'd55: begin res = v; n = 4'd2; end
         8'd1, 8'd56, 8'd57, 8'd59: if (!fits_i32(v)) st = ST_OVF;
            else begin res = v; n = 4'd4; end
         default: st = ST_UNSUP;
      endcase
      if (st != ST_OK) n = 4'd0;
      r.new_bytes = (n == 4'd0) ? it.old_bytes : merge(it.old_bytes, res, n);
      r.write_bytes = n;
      r.status = st;
      patch = r;
   endfunction
endpackage

// File: rtl/rrp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module rrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/rrp_front.sv
// Front end: accepts relocation entries, forms S+A-P and the lookup key.
// Depends on rrp_pkg.
module rrp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       base,
   input  logic              in_valid,
   output logic              in_ready,
   input  rrp_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output rrp_pkg::item_type out_item
);
   logic              valid_ff, valid_in;
   rrp_pkg::item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item = item_ff;

   always_comb begin
      logic [63:0] p;
      logic [63:0] sa;
      p = base + {32'd0, in_item.place_offset};
      sa = in_item.sym_value + in_item.val;
      item_in = in_item;
      item_in.val = rrp_pkg::is_pcrel(in_item.rel_type) ? sa - p : sa;
      item_in.key = in_item.sym_value - base;
      item_in.is_hi = (in_item.rel_type >= 8'd20) && (in_item.rel_type <= 8'd23);
      item_in.is_lo = (in_item.rel_type == 8'd24) || (in_item.rel_type == 8'd25);
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (in_valid && in_ready) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_valid && in_ready) item_ff <= item_in;
   end
endmodule

// File: rtl/rrp_queue.sv
// Short queue between front and back ends, flop based.
// Depends on rrp_pkg.
module rrp_queue #(
   parameter int DEPTH = rrp_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rrp_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output rrp_pkg::item_type out_item
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   rrp_pkg::item_type slot_ff [DEPTH];
   logic [AW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item = slot_ff[rd_ff];
   assign do_push = in_valid && in_ready;
   assign do_pop = out_valid && out_ready;

   always_comb begin
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (do_pop) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wr_ff] <= in_item;
   end
endmodule

// File: rtl/rrp_back.sv
// Back end: HI20 table, newest-first search for LO12, patch and result register.
// Depends on rrp_pkg, rrp_ram and assert_macros.svh.
`include "assert_macros.svh"
module rrp_back #(
   parameter int HI_DEPTH = rrp_pkg::HiTableDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rrp_pkg::item_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output rrp_pkg::result_type out_res
);
   localparam int AW = (HI_DEPTH > 1) ? $clog2(HI_DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   rrp_pkg::item_type   item_ff;
   rrp_pkg::result_type res_ff;
   logic          res_valid_ff;
   logic [AW:0]   count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW:0]   k_ff, k_in;
   logic [AW-1:0] rd_addr;
   logic [63:0]   found_ff, found_in;
   logic [31:0]   rd_off;
   logic [63:0]   rd_val;
   logic          wr_en;
   logic          take;
   logic [AW:0]   cnt_eff;

   assign take = in_valid && in_ready;
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = res_valid_ff;
   assign out_res = res_ff;
   // section start clears the count before the entry is handled
   assign cnt_eff = item_ff.section_start ? '0 : count_ff;
   assign wr_en = (state_ff == S_DONE) && item_ff.is_hi && (!res_valid_ff || out_ready);

   // newest-first index: head-1-k mod depth
   always_comb begin
      logic [AW:0] h;
      h = {1'b0, (item_ff.section_start ? AW'(0) : head_ff)} + (AW+1)'(HI_DEPTH) - 1'b1
          - k_ff;
      rd_addr = (h >= (AW+1)'(HI_DEPTH)) ? AW'(h - (AW+1)'(HI_DEPTH)) : h[AW-1:0];
   end

   rrp_ram #(.WIDTH(32), .DEPTH(HI_DEPTH)) u_off (
      .clock(clock), .wr_en(wr_en), .wr_addr(item_ff.section_start ? AW'(0) : head_ff),
      .wr_data(item_ff.place_offset), .rd_addr(rd_addr), .rd_data(rd_off));
   rrp_ram #(.WIDTH(64), .DEPTH(HI_DEPTH)) u_val (
      .clock(clock), .wr_en(wr_en), .wr_addr(item_ff.section_start ? AW'(0) : head_ff),
      .wr_data(item_ff.sym_value), .rd_addr(rd_addr), .rd_data(rd_val));

   always_comb begin
      logic [AW-1:0] hb;
      state_in = state_ff;
      k_in = k_ff;
      found_in = found_ff;
      count_in = count_ff;
      head_in = head_ff;
      hb = item_ff.section_start ? AW'(0) : head_ff;
      case (state_ff)
         S_IDLE: if (take) begin
            k_in = '0;
            found_in = '0;
            state_in = in_item.is_lo ? S_READ : S_DONE;
         end
         S_READ: state_in = (k_ff < cnt_eff) ? S_CMP : S_DONE;
         S_CMP: begin
            // search transaction: each table entry is read in S_READ and compared in S_CMP
            if ({32'd0, rd_off} == item_ff.key) begin
               found_in = rd_val;
               state_in = S_DONE;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: if (!res_valid_ff || out_ready) begin
            state_in = S_IDLE;
            count_in = cnt_eff;
            head_in = hb;
            if (item_ff.is_hi) begin
               head_in = (hb == AW'(HI_DEPTH - 1)) ? '0 : hb + 1'b1;
               if (cnt_eff < (AW+1)'(HI_DEPTH)) count_in = cnt_eff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_valid_ff <= 1'b0;
         count_ff <= '0;
         head_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff <= head_in;
         k_ff <= k_in;
         if (state_ff == S_DONE && (!res_valid_ff || out_ready)) res_valid_ff <= 1'b1;
         else if (out_ready) res_valid_ff <= 1'b0;
      end
      found_ff <= found_in;
      if (take) item_ff <= in_item;
      if (state_ff == S_DONE && (!res_valid_ff || out_ready))
         res_ff <= rrp_pkg::patch(item_ff, found_ff);
   end

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= (AW+1)'(HI_DEPTH),
      "hi table count beyond depth")
   `ASSERT_NEXT(a_hold_result, clock, reset, res_valid_ff && !out_ready,
      res_valid_ff && $stable(res_ff), "pending result changed while stalled")
   `ASSERT_IMPL(a_search_bound, clock, reset, state_ff == S_CMP, k_ff < cnt_eff,
      "search ran past the valid entries")
endmodule

// File: rtl/riscv_relocation_patcher_unit.sv
// RISC-V RELA relocation patcher, top level: front end, queue, back end.
// Depends on rrp_pkg, rrp_front, rrp_queue, rrp_back, rrp_ram.
// One entry in, one result out. An entry is registered in the front end, queued,
// then registered in the back end, which goes from S_IDLE to S_DONE and registers
// the result; the back end takes no new entry until it is back in S_IDLE. A
// PC-relative LO12 entry also passes S_READ and S_CMP per HI20 table entry searched
// (newest first, up to HI_DEPTH entries), plus one more S_READ when nothing matches,
// set by the one-read table RAM. The HI20 table needs no clearing pass after reset.
module riscv_relocation_patcher_unit #(
   parameter int HI_DEPTH = rrp_pkg::HiTableDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rel_type,
   input  logic [63:0] req_sym_value,
   input  logic signed [63:0] req_addend,
   input  logic [31:0] req_place_offset,
   input  logic [63:0] req_old_bytes,
   input  logic        req_section_start,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_new_bytes,
   output logic [3:0]  rsp_write_bytes,
   output logic [1:0]  rsp_status
);
   logic [63:0] base_ff;
   rrp_pkg::item_type   in_item, f_item, q_item;
   rrp_pkg::result_type res;
   logic in_ready, f_valid, f_ready, q_valid, q_ready, r_valid;

   always_ff @(posedge clock) begin
      if (reset) base_ff <= '0;
      else if (csr_we) base_ff <= csr_wdata;
   end

   always_comb begin
      in_item = '0;
      in_item.rel_type = req_rel_type;
      in_item.sym_value = req_sym_value;
      in_item.val = req_addend;
      in_item.place_offset = req_place_offset;
      in_item.old_bytes = req_old_bytes;
      in_item.section_start = req_section_start;
   end

   assign full = !in_ready;
   assign empty = !r_valid;
   assign rsp_new_bytes = res.new_bytes;
   assign rsp_write_bytes = res.write_bytes;
   assign rsp_status = res.status;

   rrp_front u_front (
      .clock(clock), .reset(reset), .base(base_ff),
      .in_valid(push), .in_ready(in_ready), .in_item(in_item),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item));

   rrp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   rrp_back #(.HI_DEPTH(HI_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(r_valid), .out_ready(pop), .out_res(res));
endmodule

// File: test/tb_riscv_relocation_patcher_unit.sv
// Testbench for riscv_relocation_patcher_unit: random and directed RELA entries,
// checked against an in-bench relocation calculator. Depends on rrp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_riscv_relocation_patcher_unit;
   // psABI relocation numbers
   localparam logic [7:0] R_NONE = 8'd0, R_32 = 8'd1, R_64 = 8'd2, R_BRANCH = 8'd16,
      R_JAL = 8'd17, R_CALL = 8'd18, R_CALL_PLT = 8'd19, R_GOT_HI20 = 8'd20,
      R_TLS_GOT_HI20 = 8'd21, R_TLS_GD_HI20 = 8'd22, R_PCREL_HI20 = 8'd23,
      R_PCREL_LOW_I = 8'd24, R_PCREL_LOW_S = 8'd25, R_HI20 = 8'd26, R_LO12_I = 8'd27,
      R_LO12_S = 8'd28, R_TPREL_HI20 = 8'd29, R_TPREL_LO12_I = 8'd30,
      R_TPREL_LO12_S = 8'd31, R_TPREL_ADD = 8'd32, R_ADD8 = 8'd33, R_ADD16 = 8'd34,
      R_ADD32 = 8'd35, R_ADD64 = 8'd36, R_SUB8 = 8'd37, R_SUB16 = 8'd38, R_SUB32 = 8'd39,
      R_SUB64 = 8'd40, R_RVC_BRANCH = 8'd44, R_RVC_JUMP = 8'd45, R_RVC_LUI = 8'd46,
      R_SUB6 = 8'd52, R_SET6 = 8'd53, R_SET8 = 8'd54, R_SET16 = 8'd55, R_SET32 = 8'd56,
      R_32_PCREL = 8'd57, R_PLT32 = 8'd59, R_UNKNOWN = 8'd255;
   localparam int TableDepth = 64;

   typedef struct {
      logic [7:0]  rtype;
      logic [63:0] sym;
      logic [63:0] addend;
      logic [31:0] off;
      logic [63:0] old;
      logic        sstart;
   } rela_type;

   typedef struct {
      logic [63:0] bytes;
      logic [3:0]  nbytes;
      logic [1:0]  status;
   } patch_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [63:0] csr_wdata = '0;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   rela_type drv = '{R_NONE, '0, '0, '0, '0, 1'b0};
   logic [63:0] rsp_new_bytes;
   logic [3:0]  rsp_write_bytes;
   logic [1:0]  rsp_status;

   riscv_relocation_patcher_unit i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .push(push), .full(full),
      .req_rel_type(drv.rtype), .req_sym_value(drv.sym), .req_addend(drv.addend),
      .req_place_offset(drv.off), .req_old_bytes(drv.old),
      .req_section_start(drv.sstart),
      .empty(empty), .pop(pop), .rsp_new_bytes(rsp_new_bytes),
      .rsp_write_bytes(rsp_write_bytes), .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   rela_type  pending_entries[$];
   patch_type expected_patches[$];
   int     mismatches = 0;
   bit     no_idle = 1'b0;
   bit     offered = 1'b0;

   // calculator state
   logic [63:0] user_base = '0;
   logic [31:0] hi_off[TableDepth];
   logic [63:0] hi_sym[TableDepth];
   int          hi_cnt = 0, hi_head = 0;

   // generator view of HI20 offsets recorded so far in this section
   logic [31:0] gen_hi[$];

   function automatic bit lo_in(logic [63:0] v, int lim);
      logic signed [31:0] s;
      s = v[31:0];
      return (s < lim) && (s >= -lim);
   endfunction

   function automatic bit fits32(logic [63:0] v);
      return {{32{v[31]}}, v[31:0]} == v;
   endfunction

   function automatic logic [31:0] u_field(logic [31:0] w, logic [63:0] v);
      logic [31:0] t;
      t = v[31:0] + 32'h800;
      return {t[31:12], w[11:0]};
   endfunction

   function automatic logic [31:0] i_field(logic [31:0] w, logic [63:0] v);
      return {v[11:0], w[19:0]};
   endfunction

   function automatic logic [31:0] s_field(logic [31:0] w, logic [63:0] v);
      return {v[11:5], w[24:12], v[4:0], w[6:0]};
   endfunction

   function automatic patch_type relocate(rela_type e);
      patch_type r;
      logic [63:0] p, v, res, found, m;
      logic [31:0] w;
      logic [15:0] h;
      logic [7:0]  b;
      int n, st, idx;
      p = user_base + {32'd0, e.off};
      v = e.sym + e.addend;
      w = e.old[31:0];
      h = e.old[15:0];
      b = e.old[7:0];
      res = '0;
      n = 0;
      st = rrp_pkg::ST_OK;
      if (e.sstart) begin
         hi_cnt = 0;
         hi_head = 0;
      end
      case (e.rtype)
         R_NONE, R_TPREL_ADD: ;
         R_64: begin res = v; n = 8; end
         R_BRANCH: begin
            v -= p;
            if (!lo_in(v, 4096)) st = rrp_pkg::ST_OVF;
            else begin
               res = {32'd0, w & 32'h01fff07f};
               res[31] = v[12]; res[30:25] = v[10:5]; res[11:8] = v[4:1]; res[7] = v[11];
               n = 4;
            end
         end
         R_JAL: begin
            v -= p;
            if (!lo_in(v, 1 << 20)) st = rrp_pkg::ST_OVF;
            else begin
               res = {32'd0, v[20], v[10:1], v[11], v[19:12], w[11:0]};
               n = 4;
            end
         end
         R_CALL, R_CALL_PLT: begin
            v -= p;
            res = {i_field(e.old[63:32], v), u_field(w, v)};
            n = 8;
         end
         R_GOT_HI20, R_TLS_GOT_HI20, R_TLS_GD_HI20, R_PCREL_HI20, R_HI20, R_TPREL_HI20:
         begin
            if (e.rtype <= R_PCREL_HI20) begin
               v -= p;
               hi_off[hi_head] = e.off;
               hi_sym[hi_head] = e.sym;
               hi_head = (hi_head + 1) % TableDepth;
               if (hi_cnt < TableDepth) hi_cnt++;
            end
            if (!fits32(v)) st = rrp_pkg::ST_OVF;
            else begin res = {32'd0, u_field(w, v)}; n = 4; end
         end
         R_PCREL_LOW_I, R_PCREL_LOW_S, R_LO12_I, R_LO12_S, R_TPREL_LO12_I, R_TPREL_LO12_S:
         begin
            if (e.rtype == R_PCREL_LOW_I || e.rtype == R_PCREL_LOW_S) begin
               found = '0;
               for (int k = 0; k < hi_cnt; k++) begin
                  idx = (hi_head + TableDepth - 1 - k) % TableDepth;
                  if (found == '0 && {32'd0, hi_off[idx]} == e.sym - user_base) begin
                     found = hi_sym[idx];
                     break;
                  end
               end
               if (found == '0) st = rrp_pkg::ST_NOHI;
               v = found - e.sym;
            end
            if (e.rtype == R_PCREL_LOW_I || e.rtype == R_LO12_I || e.rtype == R_TPREL_LO12_I)
               res = {32'd0, i_field(w, v)};
            else
               res = {32'd0, s_field(w, v)};
            n = 4;
         end
         R_ADD8: begin res = e.old + v; n = 1; end
         R_ADD16: begin res = e.old + v; n = 2; end
         R_ADD32: begin res = e.old + v; n = 4; end
         R_ADD64: begin res = e.old + v; n = 8; end
         R_SUB8: begin res = e.old - v; n = 1; end
         R_SUB16: begin res = e.old - v; n = 2; end
         R_SUB32: begin res = e.old - v; n = 4; end
         R_SUB64: begin res = e.old - v; n = 8; end
         R_RVC_BRANCH: begin
            v -= p;
            if (!lo_in(v, 256)) st = rrp_pkg::ST_OVF;
            else begin
               res = {48'd0, h[15:13], v[8], v[4:3], h[9:7], v[7:6], v[2:1], v[5], h[1:0]};
               n = 2;
            end
         end
         R_RVC_JUMP: begin
            v -= p;
            if (!lo_in(v, 2048)) st = rrp_pkg::ST_OVF;
            else begin
               res = {48'd0, h[15:13], v[11], v[4], v[9:8], v[10], v[6], v[7], v[3:1], v[5],
                      h[1:0]};
               n = 2;
            end
         end
         R_RVC_LUI: begin
            if (!lo_in(v, 1 << 17) || v[17:12] == 6'd0) st = rrp_pkg::ST_OVF;
            else begin
               res = {48'd0, h[15:13], v[17], h[11:7], v[16:12], h[1:0]};
               n = 2;
            end
         end
         R_SUB6: begin res = {56'd0, b[7:6], 6'(b[5:0] - v[5:0])}; n = 1; end
         R_SET6: begin res = {56'd0, b[7:6], v[5:0]}; n = 1; end
         R_SET8: begin res = v; n = 1; end
         R_SET16: begin res = v; n = 2; end
         R_32, R_SET32, R_32_PCREL, R_PLT32: begin
            if (e.rtype == R_32_PCREL || e.rtype == R_PLT32) v -= p;
            if (!fits32(v)) st = rrp_pkg::ST_OVF;
            else begin res = v; n = 4; end
         end
         default: st = rrp_pkg::ST_UNSUP;
      endcase
      if (st != rrp_pkg::ST_OK) n = 0;
      m = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      r.bytes = (e.old & ~m) | (res & m);
      r.nbytes = 4'(n);
      r.status = 2'(st);
      return r;
   endfunction

   // sender: acceptance is bookkept at the rising edge, the port changes at the falling one
   always @(posedge clock) begin
      offered <= push && full;
      if (!reset && push && !full) begin
         expected_patches.push_back(relocate(drv));
         void'(pending_entries.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (offered) begin
         push <= 1'b1;
      end else if (pending_entries.size() > 0 &&
                   (no_idle || $urandom_range(99) >= 12)) begin
         push <= 1'b1;
         drv <= pending_entries[0];
      end else begin
         push <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock)
      pop <= !reset && (no_idle || $urandom_range(99) >= 12);

   always @(posedge clock) begin
      patch_type x;
      if (!reset && pop && !empty) begin
         if (expected_patches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: bytes %h n %0d st %0d",
                        rsp_new_bytes, rsp_write_bytes, rsp_status);
         end else begin
            x = expected_patches.pop_front();
            if (x.bytes !== rsp_new_bytes || x.nbytes !== rsp_write_bytes ||
                x.status !== rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp bytes %h n %0d st %0d, got bytes %h n %0d st %0d",
                           x.bytes, x.nbytes, x.status,
                           rsp_new_bytes, rsp_write_bytes, rsp_status);
            end
         end
      end
   end

   function automatic rela_type make_entry(logic [7:0] t, logic [31:0] off,
                                           logic [63:0] target, logic sstart);
      rela_type e;
      e.rtype = t;
      e.off = off;
      e.sym = {$urandom, $urandom};
      e.addend = target - e.sym;
      e.old = {$urandom, $urandom};
      e.sstart = sstart;
      return e;
   endfunction

   function automatic logic [63:0] rand_delta();
      int k;
      logic [63:0] d;
      k = $urandom_range(34);
      d = {$urandom, $urandom} & ((64'd1 << k) - 64'd1);
      return $urandom_range(1) ? d : -d;
   endfunction

   function automatic bit pc_type(logic [7:0] t);
      return t inside {R_BRANCH, R_JAL, R_CALL, R_CALL_PLT, R_GOT_HI20, R_TLS_GOT_HI20,
                       R_TLS_GD_HI20, R_PCREL_HI20, R_RVC_BRANCH, R_RVC_JUMP,
                       R_32_PCREL, R_PLT32};
   endfunction

   task automatic queue_random(int count);
      logic [7:0] known[] = '{R_NONE, R_32, R_64, R_BRANCH, R_JAL, R_CALL, R_CALL_PLT,
         R_GOT_HI20, R_TLS_GOT_HI20, R_TLS_GD_HI20, R_PCREL_HI20, R_PCREL_LOW_I,
         R_PCREL_LOW_S, R_HI20, R_LO12_I, R_LO12_S, R_TPREL_HI20, R_TPREL_LO12_I,
         R_TPREL_LO12_S, R_TPREL_ADD, R_ADD8, R_ADD16, R_ADD32, R_ADD64, R_SUB8, R_SUB16,
         R_SUB32, R_SUB64, R_RVC_BRANCH, R_RVC_JUMP, R_RVC_LUI, R_SUB6, R_SET6, R_SET8,
         R_SET16, R_SET32, R_32_PCREL, R_PLT32};
      rela_type e;
      logic [7:0] t;
      logic [31:0] off;
      logic sstart;
      for (int i = 0; i < count; i++) begin
         t = ($urandom_range(99) < 92) ? known[$urandom_range(known.size() - 1)]
                                       : 8'($urandom_range(255));
         off = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1023) * 4);
         sstart = ($urandom_range(99) < 3);
         if (sstart) gen_hi.delete();
         if (pc_type(t))
            e = make_entry(t, off, user_base + off + rand_delta(), sstart);
         else
            e = make_entry(t, off, rand_delta(), sstart);
         if ((t == R_PCREL_LOW_I || t == R_PCREL_LOW_S) && gen_hi.size() > 0 &&
             $urandom_range(99) < 85) begin
            e.sym = user_base + gen_hi[$urandom_range(gen_hi.size() - 1)];
            e.addend = {$urandom, $urandom};
         end
         if (t inside {R_GOT_HI20, R_TLS_GOT_HI20, R_TLS_GD_HI20, R_PCREL_HI20}) begin
            if ($urandom_range(19) == 0) begin
               e.addend = e.addend + e.sym;
               e.sym = '0;
            end
            gen_hi.push_back(off);
            if (gen_hi.size() > 70) void'(gen_hi.pop_front());
         end
         pending_entries.push_back(e);
      end
   endtask

   task automatic drain();
      wait (pending_entries.size() == 0 && expected_patches.size() == 0 && !push);
      @(posedge clock);
   endtask

   task automatic set_base(logic [63:0] b);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= b;
      @(negedge clock);
      csr_we <= 1'b0;
      user_base = b;
   endtask

   initial begin
      logic [63:0] bases[4];
      rela_type e;
      bases = '{64'h0, {$urandom, $urandom}, 64'hffff_ffff_ffff_f000, '1};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_base(64'h0000_0000_8000_0000);

      // directed: extremes, no-op and unknown types, HI/LO pairing, table wrap
      pending_entries.push_back(make_entry(R_NONE, '0, '0, 1'b1));
      pending_entries.push_back(make_entry(R_TPREL_ADD, '1, '1, 1'b0));
      pending_entries.push_back(make_entry(R_UNKNOWN, '1, '1, 1'b0));
      pending_entries.push_back(make_entry(8'd3, '0, '0, 1'b0));
      pending_entries.push_back('{R_ADD64, '1, '1, '1, '1, 1'b0});
      pending_entries.push_back('{R_SUB64, '0, '0, '0, '0, 1'b0});
      pending_entries.push_back(make_entry(R_BRANCH, 32'h10, user_base + 32'h10 + 4094, 0));
      pending_entries.push_back(make_entry(R_BRANCH, 32'h10, user_base + 32'h10 + 4096, 0));
      pending_entries.push_back(make_entry(R_BRANCH, 32'h10, user_base + 32'h10 - 4096, 0));
      pending_entries.push_back(make_entry(R_RVC_LUI, '0, 64'h0000_0fff, 1'b0));
      pending_entries.push_back(make_entry(R_RVC_LUI, '0, 64'hffff_ffff_fffe_0000, 1'b0));
      pending_entries.push_back(make_entry(R_PCREL_HI20, 32'h100, user_base + 32'h9000, 0));
      e = make_entry(R_PCREL_LOW_I, '0, '0, 1'b0);
      e.sym = user_base + 32'h100;
      pending_entries.push_back(e);
      e.rtype = R_PCREL_LOW_S;
      e.sym = user_base + 32'h104;           // no HI20 at this place
      pending_entries.push_back(e);
      e = '{R_PCREL_HI20, '0, user_base + 32'h200, 32'h200, '0, 1'b0};  // symbol zero
      pending_entries.push_back(e);
      e = '{R_PCREL_LOW_I, user_base + 32'h200, '0, '0, '0, 1'b0};
      pending_entries.push_back(e);
      e = '{R_PCREL_LOW_I, user_base + 32'h100, '0, '0, '1, 1'b1};  // cleared first
      pending_entries.push_back(e);
      for (int i = 0; i < TableDepth + 4; i++)
         pending_entries.push_back(make_entry(R_GOT_HI20, 32'(i * 4), user_base + i, 0));
      for (int i = 0; i < 6; i++)
         pending_entries.push_back('{R_PCREL_LOW_I, user_base + 32'(i * 4), '0, '0, '0, 0});
      drain();

      foreach (bases[j]) begin
         set_base(bases[j]);
         gen_hi.delete();
         no_idle = 1'b0;
         queue_random(250);
         drain();
         no_idle = 1'b1;
         queue_random(120);
         drain();
         no_idle = 1'b0;
         queue_random(120);
         drain();
      end
      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_patches.size() == 0)
         $display("tb_riscv_relocation_patcher_unit: clean");
      else
         $display("tb_riscv_relocation_patcher_unit: errors");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_riscv_relocation_patcher_unit: errors");
      $finish;
   end
endmodule
